>>> hdl/c2s_pkg.sv
// shared types, constants and the cordic step for the cartesian to spherical converter
`timescale 1ns / 1ps
`default_nettype none

package c2s_pkg;

   // coordinate and pipeline sizing
   localparam int COORD_WIDTH   = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int FRAC_BITS     = 14;

   // output field widths
   localparam int RADIUS_W    = 16;
   localparam int ANGLE_OUT_W = 16;

   // internal angle word, 2^31 is pi
   localparam int ANGLE_W = 32;
   localparam int ATAN_N  = 32;

   // squares and square root lanes
   localparam int SQ_W    = 2 * COORD_WIDTH;
   localparam int R_STEPS = COORD_WIDTH;
   localparam int R_REM_W = COORD_WIDTH + 2;
   localparam int H_STEPS = COORD_WIDTH + FRAC_BITS;
   localparam int H_W     = H_STEPS;
   localparam int H_REM_W = H_W + 2;
   localparam int RSUM_W  = (COORD_WIDTH + 1 > RADIUS_W) ? COORD_WIDTH + 1 : RADIUS_W;

   // cordic datapath width, room for the gain and the sign
   localparam int CORD_W = COORD_WIDTH + FRAC_BITS + 4;

   // elevation after the rounding shift
   localparam int ELSH_W = ANGLE_W + 1 - ANGLE_OUT_W;

   typedef logic [ANGLE_W-1:0] angle_type;

   localparam angle_type ANGLE_PI   = 32'h8000_0000;
   localparam angle_type ANGLE_HALF = 32'h0000_8000;

   localparam logic [RADIUS_W-1:0] RAD_MAX = '1;

   localparam logic signed [ANGLE_OUT_W-1:0] ELEV_MAX = 16'sd16384;
   localparam logic signed [ANGLE_OUT_W-1:0] ELEV_MIN = -16'sd16384;

   // atan(2^-i) in units of pi/2^31
   localparam angle_type ATAN_TAB [ATAN_N] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // per-stage side band: valid bit and origin flag
   typedef struct packed {
      logic valid;
      logic zero;
   } ctl_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } point_type;

   // one cordic vectoring lane; byp holds the start angle when y starts at zero
   typedef struct packed {
      logic signed [CORD_W-1:0] px;
      logic signed [CORD_W-1:0] py;
      angle_type                ang;
      logic                     byp;
   } lane_type;

   // one vectoring micro-rotation, shift by sh
   function automatic lane_type cordic_step(lane_type l, logic [4:0] sh);
      lane_type                 o;
      logic signed [CORD_W-1:0] px_s;
      logic signed [CORD_W-1:0] py_s;
      logic signed [CORD_W-1:0] dx;
      logic signed [CORD_W-1:0] dy;
      o    = l;
      px_s = l.px;
      py_s = l.py;
      dx   = py_s >>> sh;
      dy   = px_s >>> sh;
      if (!l.byp) begin
         if (!py_s[CORD_W-1]) begin
            o.px  = px_s + dx;
            o.py  = py_s - dy;
            o.ang = l.ang + ATAN_TAB[sh];
         end else begin
            o.px  = px_s - dx;
            o.py  = py_s + dy;
            o.ang = l.ang - ATAN_TAB[sh];
         end
      end
      return o;
   endfunction

endpackage

`default_nettype wire

>>> hdl/c2s_root_pipe.sv
// squares and the two digit-serial square root lanes (radius and horizontal length)
`timescale 1ns / 1ps
`default_nettype none

module c2s_root_pipe import c2s_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  point_type           in_pt,
   output ctl_type             out_ctl,
   output point_type           out_pt,
   output logic [H_W-1:0]      out_h,
   output logic [RADIUS_W-1:0] out_radius
);

   logic signed [SQ_W-1:0] x_ext;
   logic signed [SQ_W-1:0] y_ext;
   logic signed [SQ_W-1:0] z_ext;
   logic [SQ_W-1:0]        xx_in;
   logic [SQ_W-1:0]        yy_in;
   logic [SQ_W-1:0]        zz_in;
   logic [SQ_W-1:0]        xx_ff;
   logic [SQ_W-1:0]        yy_ff;
   logic [SQ_W-1:0]        zz_ff;
   logic [SQ_W-1:0]        hsq_in;
   logic [SQ_W-1:0]        s_in;
   logic [SQ_W-1:0]        hsq_ff;
   logic [SQ_W-1:0]        s_ff;
   point_type              pt_a_ff;
   point_type              pt_b_ff;
   ctl_type                ctl_a_ff;
   ctl_type                ctl_b_ff;

   logic [SQ_W-1:0]        h_op_ff  [R_STEPS-1];
   logic [H_W-1:0]         h_q_ff   [H_STEPS];
   logic [H_REM_W-1:0]     h_rem_ff [H_STEPS-1];
   logic [SQ_W-1:0]        r_op_ff  [R_STEPS-1];
   logic [COORD_WIDTH-1:0] r_q_ff   [R_STEPS];
   logic [R_REM_W-1:0]     r_rem_ff [R_STEPS];
   logic [RADIUS_W-1:0]    rad_ff   [H_STEPS-R_STEPS];
   point_type              pt_ff    [H_STEPS];
   ctl_type                ctl_ff   [H_STEPS];

   // stage a: squares
   assign x_ext = SQ_W'(in_pt.x);
   assign y_ext = SQ_W'(in_pt.y);
   assign z_ext = SQ_W'(in_pt.z);
   assign xx_in = unsigned'(x_ext * x_ext);
   assign yy_in = unsigned'(y_ext * y_ext);
   assign zz_in = unsigned'(z_ext * z_ext);

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff   <= xx_in;
         yy_ff   <= yy_in;
         zz_ff   <= zz_in;
         pt_a_ff <= in_pt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
      end else if (adv) begin
         ctl_a_ff.valid <= in_valid;
         ctl_a_ff.zero  <= 1'b0;
      end
   end

   // stage b: horizontal and full sums of squares
   assign hsq_in = xx_ff + yy_ff;
   assign s_in   = hsq_in + zz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hsq_ff  <= hsq_in;
         s_ff    <= s_in;
         pt_b_ff <= pt_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_b_ff <= '0;
      end else if (adv) begin
         ctl_b_ff.valid <= ctl_a_ff.valid;
         ctl_b_ff.zero  <= (s_in == '0);
      end
   end

   // horizontal length: one root bit per stage of hsq scaled by 2^(2*frac)
   for (genvar k = 0; k < H_STEPS; k++) begin : g_h
      logic [1:0]         pair;
      logic [H_W-1:0]     q_prev;
      logic [H_REM_W-1:0] rem_prev;
      logic [H_REM_W-1:0] rem_sh;
      logic [H_REM_W-1:0] trial;
      logic               ge;

      if (k == 0) begin : g_src
         assign pair     = hsq_ff[SQ_W-1 -: 2];
         assign q_prev   = '0;
         assign rem_prev = '0;
      end else if (k < R_STEPS) begin : g_mid
         assign pair     = h_op_ff[k-1][SQ_W-1 -: 2];
         assign q_prev   = h_q_ff[k-1];
         assign rem_prev = h_rem_ff[k-1];
      end else begin : g_frac
         // fraction bits: the operand is all zeros from here on
         assign pair     = 2'b00;
         assign q_prev   = h_q_ff[k-1];
         assign rem_prev = h_rem_ff[k-1];
      end

      assign rem_sh = {rem_prev[H_REM_W-3:0], pair};
      assign trial  = {q_prev, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            h_q_ff[k] <= {q_prev[H_W-2:0], ge};
         end
      end

      if (k < H_STEPS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               h_rem_ff[k] <= ge ? rem_sh - trial : rem_sh;
            end
         end
      end

      if (k == 0) begin : g_op0
         always_ff @(posedge clock) begin
            if (adv) begin
               h_op_ff[k] <= {hsq_ff[SQ_W-3:0], 2'b00};
            end
         end
      end else if (k < R_STEPS - 1) begin : g_opn
         always_ff @(posedge clock) begin
            if (adv) begin
               h_op_ff[k] <= {h_op_ff[k-1][SQ_W-3:0], 2'b00};
            end
         end
      end
   end

   // radius: one root bit per stage of the full sum
   for (genvar k = 0; k < R_STEPS; k++) begin : g_r
      logic [1:0]             pair;
      logic [COORD_WIDTH-1:0] q_prev;
      logic [R_REM_W-1:0]     rem_prev;
      logic [R_REM_W-1:0]     rem_sh;
      logic [R_REM_W-1:0]     trial;
      logic                   ge;

      if (k == 0) begin : g_src
         assign pair     = s_ff[SQ_W-1 -: 2];
         assign q_prev   = '0;
         assign rem_prev = '0;
      end else begin : g_mid
         assign pair     = r_op_ff[k-1][SQ_W-1 -: 2];
         assign q_prev   = r_q_ff[k-1];
         assign rem_prev = r_rem_ff[k-1];
      end

      assign rem_sh = {rem_prev[R_REM_W-3:0], pair};
      assign trial  = {q_prev, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            r_q_ff[k]   <= {q_prev[COORD_WIDTH-2:0], ge};
            r_rem_ff[k] <= ge ? rem_sh - trial : rem_sh;
         end
      end

      if (k == 0) begin : g_op0
         always_ff @(posedge clock) begin
            if (adv) begin
               r_op_ff[k] <= {s_ff[SQ_W-3:0], 2'b00};
            end
         end
      end else if (k < R_STEPS - 1) begin : g_opn
         always_ff @(posedge clock) begin
            if (adv) begin
               r_op_ff[k] <= {r_op_ff[k-1][SQ_W-3:0], 2'b00};
            end
         end
      end
   end

   // radius rounding (remainder above root rounds up), then delay to match
   for (genvar k = R_STEPS; k < H_STEPS; k++) begin : g_rad
      if (k == R_STEPS) begin : g_round
         logic              up;
         logic [RSUM_W-1:0] sum;

         assign up  = (r_rem_ff[R_STEPS-1] > R_REM_W'(r_q_ff[R_STEPS-1]));
         assign sum = RSUM_W'(r_q_ff[R_STEPS-1]) + RSUM_W'(up);

         always_ff @(posedge clock) begin
            if (adv) begin
               rad_ff[0] <= (sum > RSUM_W'(RAD_MAX)) ? RAD_MAX : RADIUS_W'(sum);
            end
         end
      end else begin : g_delay
         always_ff @(posedge clock) begin
            if (adv) begin
               rad_ff[k-R_STEPS] <= rad_ff[k-R_STEPS-1];
            end
         end
      end
   end

   // point and side band travel with the root stages
   for (genvar k = 0; k < H_STEPS; k++) begin : g_side
      if (k == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (adv) begin
               pt_ff[k] <= pt_b_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else if (adv) begin
               ctl_ff[k] <= ctl_b_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (adv) begin
               pt_ff[k] <= pt_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else if (adv) begin
               ctl_ff[k] <= ctl_ff[k-1];
            end
         end
      end
   end

   assign out_ctl    = ctl_ff[H_STEPS-1];
   assign out_pt     = pt_ff[H_STEPS-1];
   assign out_h      = h_q_ff[H_STEPS-1];
   assign out_radius = rad_ff[H_STEPS-R_STEPS-1];

endmodule

`default_nettype wire

>>> hdl/c2s_cordic_pipe.sv
// two parallel cordic vectoring lanes: azimuth from (x, y), elevation from (h, z)
`timescale 1ns / 1ps
`default_nettype none

module c2s_cordic_pipe import c2s_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  ctl_type             in_ctl,
   input  point_type           in_pt,
   input  logic [H_W-1:0]      in_h,
   input  logic [RADIUS_W-1:0] in_radius,
   output ctl_type             out_ctl,
   output angle_type           out_az,
   output angle_type           out_el,
   output logic [RADIUS_W-1:0] out_radius
);

   logic signed [CORD_W-1:0] x_sc;
   logic signed [CORD_W-1:0] y_sc;
   logic signed [CORD_W-1:0] z_sc;
   lane_type                 az_prep;
   lane_type                 el_prep;

   lane_type                 az_ff  [CORDIC_STAGES+1];
   lane_type                 el_ff  [CORDIC_STAGES+1];
   logic [RADIUS_W-1:0]      rad_ff [CORDIC_STAGES+1];
   ctl_type                  ctl_ff [CORDIC_STAGES+1];

   // scale into the cordic format, fold negative x into the right half plane
   assign x_sc = CORD_W'(in_pt.x) <<< FRAC_BITS;
   assign y_sc = CORD_W'(in_pt.y) <<< FRAC_BITS;
   assign z_sc = CORD_W'(in_pt.z) <<< FRAC_BITS;

   always_comb begin
      az_prep.byp = (in_pt.y == '0);
      if (x_sc[CORD_W-1]) begin
         az_prep.px  = -x_sc;
         az_prep.py  = -y_sc;
         az_prep.ang = ANGLE_PI;
      end else begin
         az_prep.px  = x_sc;
         az_prep.py  = y_sc;
         az_prep.ang = '0;
      end
      el_prep.px  = signed'(CORD_W'(in_h));
      el_prep.py  = z_sc;
      el_prep.ang = '0;
      el_prep.byp = (in_pt.z == '0);
   end

   // prep stage
   always_ff @(posedge clock) begin
      if (adv) begin
         az_ff[0]  <= az_prep;
         el_ff[0]  <= el_prep;
         rad_ff[0] <= in_radius;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= in_ctl;
      end
   end

   // one micro-rotation per stage in each lane
   for (genvar i = 1; i <= CORDIC_STAGES; i++) begin : g_stage
      if (i - 1 < ATAN_N) begin : g_rot
         always_ff @(posedge clock) begin
            if (adv) begin
               az_ff[i] <= cordic_step(az_ff[i-1], 5'(i - 1));
               el_ff[i] <= cordic_step(el_ff[i-1], 5'(i - 1));
            end
         end
      end else begin : g_pass
         // past the end of the angle table a stage only delays
         always_ff @(posedge clock) begin
            if (adv) begin
               az_ff[i] <= az_ff[i-1];
               el_ff[i] <= el_ff[i-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[i] <= rad_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (adv) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   assign out_ctl    = ctl_ff[CORDIC_STAGES];
   assign out_az     = az_ff[CORDIC_STAGES].ang;
   assign out_el     = el_ff[CORDIC_STAGES].ang;
   assign out_radius = rad_ff[CORDIC_STAGES];

endmodule

`default_nettype wire

>>> hdl/cartesian_to_spherical.sv
// top level of the cartesian to spherical converter
//
// takes one point (x, y, z) per beat on the req_ channel and returns one beat on the
// rsp_ channel with the rounded radius, the azimuth atan2(y, x) and the elevation
// atan2(z, sqrt(x*x + y*y)), both angles scaled so that 32768 is pi, plus a flag for
// the origin, where all three results are zero.
// a new point is taken every cycle unless the pipe holds; results leave in the order the
// points came in. each point passes the square and sum stages, the square root stages of
// the horizontal length, the prep stage, the cordic micro-rotation stages and the output
// register; the square root chain is the longest part of the pipe.
// the whole pipeline advances together; it holds only while rsp_valid is high and
// rsp_stall is high, and then req_stall is raised in the same cycle, so nothing is
// lost or repeated. bubbles in the pipe do not block new points.
// reset (synchronous, active high) clears every valid bit; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_spherical import c2s_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  logic signed [COORD_WIDTH-1:0] req_z_coord,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [RADIUS_W-1:0]           rsp_radius,
   output logic signed [ANGLE_OUT_W-1:0] rsp_azimuth,
   output logic signed [ANGLE_OUT_W-1:0] rsp_elevation,
   output logic                          rsp_zero_radius
);

   logic                          pipe_adv;
   point_type                     req_pt;
   ctl_type                       root_ctl;
   point_type                     root_pt;
   logic [H_W-1:0]                root_h;
   logic [RADIUS_W-1:0]           root_radius;
   ctl_type                       cord_ctl;
   angle_type                     cord_az;
   angle_type                     cord_el;
   logic [RADIUS_W-1:0]           cord_radius;

   angle_type                     az_round;
   logic signed [ANGLE_W:0]       el_round;
   logic signed [ELSH_W-1:0]      el_sh;

   logic                          rsp_valid_ff;
   logic [RADIUS_W-1:0]           rsp_radius_ff;
   logic [RADIUS_W-1:0]           rsp_radius_in;
   logic signed [ANGLE_OUT_W-1:0] rsp_azimuth_ff;
   logic signed [ANGLE_OUT_W-1:0] rsp_azimuth_in;
   logic signed [ANGLE_OUT_W-1:0] rsp_elevation_ff;
   logic signed [ANGLE_OUT_W-1:0] rsp_elevation_in;
   logic                          rsp_zero_radius_ff;

   // whole pipe moves unless the output beat is held
   assign pipe_adv  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_adv;

   assign req_pt = {req_x_coord, req_y_coord, req_z_coord};

   c2s_root_pipe u_root (
      .clock      (clock),
      .reset      (reset),
      .adv        (pipe_adv),
      .in_valid   (req_valid),
      .in_pt      (req_pt),
      .out_ctl    (root_ctl),
      .out_pt     (root_pt),
      .out_h      (root_h),
      .out_radius (root_radius)
   );

   c2s_cordic_pipe u_cordic (
      .clock      (clock),
      .reset      (reset),
      .adv        (pipe_adv),
      .in_ctl     (root_ctl),
      .in_pt      (root_pt),
      .in_h       (root_h),
      .in_radius  (root_radius),
      .out_ctl    (cord_ctl),
      .out_az     (cord_az),
      .out_el     (cord_el),
      .out_radius (cord_radius)
   );

   // round the angle words to 16 bits, half up
   assign az_round = cord_az + ANGLE_HALF;
   assign el_round = signed'({cord_el[ANGLE_W-1], cord_el}) + signed'((ANGLE_W+1)'(ANGLE_HALF));
   assign el_sh    = el_round[ANGLE_W -: ELSH_W];

   // final formatting: clamp the elevation, force zeros at the origin
   always_comb begin
      rsp_radius_in = cord_radius;
      if (cord_ctl.zero) begin
         rsp_azimuth_in   = '0;
         rsp_elevation_in = '0;
      end else begin
         rsp_azimuth_in = signed'(az_round[ANGLE_W-1 -: ANGLE_OUT_W]);
         if (el_sh > ELSH_W'(ELEV_MAX)) begin
            rsp_elevation_in = ELEV_MAX;
         end else if (el_sh < ELSH_W'(ELEV_MIN)) begin
            rsp_elevation_in = ELEV_MIN;
         end else begin
            rsp_elevation_in = el_sh[ANGLE_OUT_W-1:0];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         rsp_radius_ff      <= rsp_radius_in;
         rsp_azimuth_ff     <= rsp_azimuth_in;
         rsp_elevation_ff   <= rsp_elevation_in;
         rsp_zero_radius_ff <= cord_ctl.zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         rsp_valid_ff <= cord_ctl.valid;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_radius      = rsp_radius_ff;
   assign rsp_azimuth     = rsp_azimuth_ff;
   assign rsp_elevation   = rsp_elevation_ff;
   assign rsp_zero_radius = rsp_zero_radius_ff;

endmodule

`default_nettype wire

>>> hdl/c2s_check.sv
// port-level assertions for the cartesian to spherical converter and their bind
`timescale 1ns / 1ps
`default_nettype none

module c2s_check import c2s_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [RADIUS_W-1:0]           rsp_radius,
   input logic signed [ANGLE_OUT_W-1:0] rsp_azimuth,
   input logic signed [ANGLE_OUT_W-1:0] rsp_elevation,
   input logic                          rsp_zero_radius
);

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_radius) && $stable(rsp_azimuth)
         && $stable(rsp_elevation) && $stable(rsp_zero_radius))
      else $error("held result beat changed");

   // the input side only stalls behind a stalled output beat
   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // origin gives all-zero results
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_radius |->
         (rsp_radius == '0) && (rsp_azimuth == '0) && (rsp_elevation == '0))
      else $error("origin beat with nonzero result");

   // any other point has a radius of at least one
   a_radius_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_zero_radius |-> (rsp_radius != '0))
      else $error("zero radius without origin flag");

   // elevation stays within a quarter turn
   a_elev_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elevation <= ELEV_MAX) && (rsp_elevation >= ELEV_MIN))
      else $error("elevation out of range");

endmodule

bind cartesian_to_spherical c2s_check u_c2s_check (.*);

`default_nettype wire

>>> sim/cartesian_to_spherical_tb.sv
// testbench for the cartesian to spherical converter: directed and random points checked
// against a bit-exact predictor
`timescale 1ns / 1ps

module cartesian_to_spherical_tb import c2s_pkg::*;;

   // cycles to wait after the last result for any stray beat
   localparam int DRAIN_CYCLES = 64;

   // atan(2^-i), 2^31 is pi
   localparam logic [31:0] ATAN_LUT [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [RADIUS_W-1:0]           radius;
      logic signed [ANGLE_OUT_W-1:0] azimuth;
      logic signed [ANGLE_OUT_W-1:0] elevation;
      logic                          origin;
   } sph_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [COORD_WIDTH-1:0] req_x_coord = '0;
   logic signed [COORD_WIDTH-1:0] req_y_coord = '0;
   logic signed [COORD_WIDTH-1:0] req_z_coord = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [RADIUS_W-1:0]           rsp_radius;
   logic signed [ANGLE_OUT_W-1:0] rsp_azimuth;
   logic signed [ANGLE_OUT_W-1:0] rsp_elevation;
   logic                          rsp_zero_radius;

   sph_type expected_sph[$];
   int      mismatch_count = 0;
   bit      steady = 1'b0;

   cartesian_to_spherical i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_z_coord     (req_z_coord),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_radius      (rsp_radius),
      .rsp_azimuth     (rsp_azimuth),
      .rsp_elevation   (rsp_elevation),
      .rsp_zero_radius (rsp_zero_radius)
   );

   always #2 clock = ~clock;

   // bitwise integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // vectoring rotation: drive py to zero, sum the angle
   function automatic logic [31:0] cordic_angle(longint px, longint py, logic [31:0] start);
      logic [31:0] ang;
      longint      dx;
      longint      dy;
      ang = start;
      if (py == 0) return ang;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px  += dx;
            py  -= dy;
            ang += ATAN_LUT[i];
         end else begin
            px  -= dx;
            py  += dy;
            ang -= ATAN_LUT[i];
         end
      end
      return ang;
   endfunction

   // expected radius, azimuth and elevation of one point
   function automatic sph_type predict_point(point_type p);
      sph_type         res;
      longint          x, y, z, ax, ay, hlen, e;
      longint unsigned hsq, ssq, r;
      logic [31:0]     az, el, start, az_rnd;
      x   = longint'($signed(p.x));
      y   = longint'($signed(p.y));
      z   = longint'($signed(p.z));
      hsq = x * x + y * y;
      ssq = hsq + z * z;
      r   = int_sqrt(ssq);
      if (ssq - r * r > r) r++;
      if (r > 65535) r = 65535;
      res.radius    = r[15:0];
      res.origin    = (ssq == 0);
      res.azimuth   = '0;
      res.elevation = '0;
      if (ssq != 0) begin
         ax    = x * (longint'(1) << FRAC_BITS);
         ay    = y * (longint'(1) << FRAC_BITS);
         start = '0;
         // left half plane: mirror and start at pi
         if (ax < 0) begin
            ax    = -ax;
            ay    = -ay;
            start = 32'h8000_0000;
         end
         az          = cordic_angle(ax, ay, start);
         az_rnd      = az + 32'h0000_8000;
         res.azimuth = az_rnd[31:16];
         hlen = longint'(int_sqrt(hsq << (2 * FRAC_BITS)));
         el   = cordic_angle(hlen, z * (longint'(1) << FRAC_BITS), '0);
         e    = longint'($signed(el));
         e    = (e + 32768) >>> 16;
         if (e > 16384) e = 16384;
         if (e < -16384) e = -16384;
         res.elevation = e[15:0];
      end
      return res;
   endfunction

   // a point mixing full range, small, axis, extreme and negative-x near-axis values
   function automatic point_type rand_point();
      point_type p;
      int        extremes [6] = '{-32768, -32767, -1, 0, 1, 32767};
      p.x = COORD_WIDTH'($urandom);
      p.y = COORD_WIDTH'($urandom);
      p.z = COORD_WIDTH'($urandom);
      case ($urandom_range(9))
         6: begin
            p.x = COORD_WIDTH'($urandom_range(16) - 8);
            p.y = COORD_WIDTH'($urandom_range(16) - 8);
            p.z = COORD_WIDTH'($urandom_range(16) - 8);
         end
         7: begin
            if ($urandom_range(1)) p.x = '0;
            if ($urandom_range(1)) p.y = '0;
            if ($urandom_range(1)) p.z = '0;
         end
         8: begin
            p.x = COORD_WIDTH'(extremes[$urandom_range(5)]);
            p.y = COORD_WIDTH'(extremes[$urandom_range(5)]);
            p.z = COORD_WIDTH'(extremes[$urandom_range(5)]);
         end
         9: begin
            p.x = -$signed(16'($urandom_range(32768, 1)));
            p.y = $urandom_range(1) ? '0 : COORD_WIDTH'($urandom_range(6) - 3);
         end
         default: ;
      endcase
      return p;
   endfunction

   // one request beat, with an optional gap in front; held until taken
   task automatic send_point(input point_type p);
      logic taken;
      if (!steady && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(5, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= p.x;
      req_y_coord <= p.y;
      req_z_coord <= p.z;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      expected_sph.insert(expected_sph.size(), predict_point(p));
   endtask

   task automatic compare_field(input string what, input int expd, input int act);
      if (expd != act) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, expd, act);
         mismatch_count++;
      end
   endtask

   // result side back-pressure
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 23);
   end

   // check each result beat against the oldest expectation
   always @(negedge clock) begin
      sph_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sph.size() == 0) begin
            $display("%0t: unexpected result beat: radius %0d azimuth %0d elevation %0d",
                     $time, rsp_radius, rsp_azimuth, rsp_elevation);
            mismatch_count++;
         end else begin
            want = expected_sph.pop_front();
            compare_field("radius", want.radius, rsp_radius);
            compare_field("azimuth", want.azimuth, rsp_azimuth);
            compare_field("elevation", want.elevation, rsp_elevation);
            compare_field("zero_radius", want.origin, rsp_zero_radius);
         end
      end
   end

   // origin, axes, extremes and quadrant corners
   task automatic test_directed_points();
      int        pts [21][3] = '{
         '{0, 0, 0}, '{32767, 0, 0}, '{-32768, 0, 0}, '{0, 32767, 0}, '{0, -32768, 0},
         '{0, 0, 32767}, '{0, 0, -32768}, '{1, 0, 0}, '{-1, 0, 0}, '{0, 0, 1},
         '{0, 0, -1}, '{32767, 32767, 32767}, '{-32768, -32768, -32768},
         '{-32768, 32767, -32768}, '{32767, -32768, 32767}, '{-1, 1, 0}, '{-1, -1, 0},
         '{1, -1, 1}, '{-20000, -1, 5}, '{3, 4, 12}, '{-5, 0, -7}
      };
      point_type p;
      foreach (pts[i]) begin
         p.x = COORD_WIDTH'(pts[i][0]);
         p.y = COORD_WIDTH'(pts[i][1]);
         p.z = COORD_WIDTH'(pts[i][2]);
         send_point(p);
      end
   endtask

   // full rate on both sides, no gaps and no stalls
   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (200) send_point(rand_point());
      steady = 1'b0;
   endtask

   // random points with gaps and stalls on both sides
   task automatic test_random_points();
      repeat (1000) send_point(rand_point());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_points();
      test_back_to_back();
      test_random_points();
      req_valid <= 1'b0;
      while (expected_sph.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d results outstanding", $time, expected_sph.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
